@@ src/assert_macros.svh @@
// Assertion helpers shared by the verifier modules.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define DTV_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define DTV_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ src/dtv_pkg.sv @@
`default_nettype none

package dtv_pkg;

  localparam logic [15:0] CrcPoly   = 16'h1021;
  localparam logic [15:0] MaxCrcLen = 16'd8192;
  localparam logic [15:0] IdLowMax  = 16'd9;
  localparam logic [15:0] IdHighMin = 16'd256;
  localparam logic [15:0] IdMax     = 16'd266;

  localparam int unsigned QueueDepth = 4;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CHECKSUM  = 3'd1,
    ST_ID        = 3'd2,
    ST_VERSION   = 3'd3,
    ST_TOO_LONG  = 3'd4,
    ST_CRC       = 3'd5,
    ST_LOCATION  = 3'd6,
    ST_TRUNCATED = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    CFG_EXPECTED_ID       = 2'd0,
    CFG_MAX_VERSION       = 2'd1,
    CFG_CHECK_LOCATION    = 2'd2,
    CFG_EXPECTED_LOCATION = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [8:0]  expected_id;
    logic [15:0] max_version;
    logic        check_location;
    logic [31:0] expected_location;
  } cfg_t;

  // One finished descriptor as handed from the front part to the back part.
  typedef struct packed {
    logic         hdr_short;
    logic         sum_bad;
    logic         body_short;
    logic         crc_bad;
    logic [127:0] hdr;
  } rec_t;

  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ src/descriptor_tag_verifier_unit.sv @@
`default_nettype none
// After the final byte of a descriptor is accepted, its record enters the queue; its result
// is then loaded into the result register once that register is empty or being read.
// Throughput: one byte per cycle; the front part takes bytes while a result waits,
// until its four-entry queue of finished descriptors is full.
// Reset clears the configuration to its defaults (max version 3, all else zero),
// the per-descriptor state, the queue and the result valid bit; no clearing pass is needed.

module descriptor_tag_verifier_unit
  import dtv_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // data_byte[7:0]
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status[2:0], tag_ident[18:3], tag_version[34:19], tag_checksum[42:35],
  // serial_number[58:43], stored_crc[74:59], crc_length[90:75],
  // tag_location[122:91], zero padding[127:123]
  output logic [127:0]      m_axis_tdata,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i
);

  cfg_t cfg_q;
  rec_t front_rec, head_rec;
  logic push, pop, full, empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_id       <= '0;
      cfg_q.max_version       <= 16'd3;
      cfg_q.check_location    <= 1'b0;
      cfg_q.expected_location <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_EXPECTED_ID:       cfg_q.expected_id       <= cfg_data_i[8:0];
        CFG_MAX_VERSION:       cfg_q.max_version       <= cfg_data_i[15:0];
        CFG_CHECK_LOCATION:    cfg_q.check_location    <= cfg_data_i[0];
        CFG_EXPECTED_LOCATION: cfg_q.expected_location <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dtv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .byte_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .full_i  (full),
    .push_o  (push),
    .rec_o   (front_rec)
  );

  dtv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (front_rec),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_rec)
  );

  dtv_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .empty_i       (empty),
    .head_i        (head_rec),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

@@ src/dtv_front.sv @@
`default_nettype none
`include "assert_macros.svh"

module dtv_front
  import dtv_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  wire logic [7:0] byte_i,
  input  wire logic       last_i,
  input  wire logic       full_i,
  output logic            push_o,
  output rec_t            rec_o
);

  logic [4:0]   hdr_idx_q, hdr_idx_d;
  logic [15:0]  body_cnt_q, body_cnt_d;
  logic [7:0]   sum_q, sum_d;
  logic [15:0]  crc_q, crc_d;
  logic [127:0] hdr_q, hdr_d;
  logic         accept;

  assign ready_o = !full_i;
  assign accept  = valid_i && !full_i;
  assign push_o  = accept && last_i;

  always_comb begin
    hdr_idx_d  = hdr_idx_q;
    body_cnt_d = body_cnt_q;
    sum_d      = sum_q;
    crc_d      = crc_q;
    hdr_d      = hdr_q;
    if (accept) begin
      if (!hdr_idx_q[4]) begin
        hdr_d[{hdr_idx_q[3:0], 3'b000} +: 8] = byte_i;
        if (hdr_idx_q != 5'd4) begin
          sum_d = sum_q + byte_i;
        end
        hdr_idx_d = hdr_idx_q + 5'd1;
      end else begin
        if (body_cnt_q < hdr_q[95:80]) begin
          crc_d = crc16_step(crc_q, byte_i);
        end
        if (body_cnt_q != 16'hffff) begin
          body_cnt_d = body_cnt_q + 16'd1;
        end
      end
    end
  end

  always_comb begin
    rec_o.hdr        = hdr_d;
    rec_o.hdr_short  = !hdr_idx_d[4];
    rec_o.sum_bad    = sum_d != hdr_d[39:32];
    rec_o.body_short = body_cnt_d < hdr_d[95:80];
    rec_o.crc_bad    = crc_d != hdr_d[79:64];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_idx_q  <= '0;
      body_cnt_q <= '0;
      sum_q      <= '0;
      crc_q      <= '0;
      hdr_q      <= '0;
    end else if (push_o) begin
      hdr_idx_q  <= '0;
      body_cnt_q <= '0;
      sum_q      <= '0;
      crc_q      <= '0;
      hdr_q      <= '0;
    end else begin
      hdr_idx_q  <= hdr_idx_d;
      body_cnt_q <= body_cnt_d;
      sum_q      <= sum_d;
      crc_q      <= crc_d;
      hdr_q      <= hdr_d;
    end
  end

  `DTV_ASSERT(a_hdr_idx_range, hdr_idx_q <= 5'd16, "header index beyond tag length")
  `DTV_ASSERT(a_clear_after_push, push_o |=> (hdr_idx_q == 5'd0 && body_cnt_q == 16'd0), "descriptor state not cleared after last byte")

endmodule

`default_nettype wire

@@ src/dtv_queue.sv @@
`default_nettype none
`include "assert_macros.svh"

module dtv_queue
  import dtv_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire rec_t rec_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output rec_t      head_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  rec_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = count_q == CntW'(QueueDepth);
  assign empty_o = count_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_d;
    end
  end

  `DTV_ASSERT_ALWAYS(a_count_range, count_q <= CntW'(QueueDepth), "queue count beyond depth")
  `DTV_ASSERT(a_no_push_full, !(push_i && full_o && !pop_i), "request written into a full queue")

endmodule

`default_nettype wire

@@ src/dtv_back.sv @@
`default_nettype none
`include "assert_macros.svh"

module dtv_back
  import dtv_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cfg_t          cfg_i,
  input  wire logic          empty_i,
  input  wire rec_t          head_i,
  output logic               pop_o,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [127:0]       m_axis_tdata
);

  logic         valid_q;
  status_e      status_q, status_d;
  logic [127:0] hdr_q;
  logic [15:0]  id, vers, len;
  logic [31:0]  loc;
  logic         id_bad;

  assign pop_o = !empty_i && (!valid_q || m_axis_tready);

  always_comb begin
    id   = head_i.hdr[15:0];
    vers = head_i.hdr[31:16];
    len  = head_i.hdr[95:80];
    loc  = head_i.hdr[127:96];
    id_bad = (id > IdLowMax && id < IdHighMin) || id > IdMax ||
             (cfg_i.expected_id != 9'd0 && id != {7'd0, cfg_i.expected_id});
    if (head_i.hdr_short) begin
      status_d = ST_TRUNCATED;
    end else if (head_i.sum_bad) begin
      status_d = ST_CHECKSUM;
    end else if (id_bad) begin
      status_d = ST_ID;
    end else if (vers > cfg_i.max_version) begin
      status_d = ST_VERSION;
    end else if (len > MaxCrcLen) begin
      status_d = ST_TOO_LONG;
    end else if (head_i.body_short) begin
      status_d = ST_TRUNCATED;
    end else if (head_i.crc_bad) begin
      status_d = ST_CRC;
    end else if (cfg_i.check_location && loc != cfg_i.expected_location) begin
      status_d = ST_LOCATION;
    end else begin
      status_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q <= status_d;
      hdr_q    <= head_i.hdr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {5'd0, hdr_q[127:96], hdr_q[95:80], hdr_q[79:64], hdr_q[63:48],
                          hdr_q[39:32], hdr_q[31:16], hdr_q[15:0], status_q};

  `DTV_ASSERT(a_pop_loads, pop_o |=> m_axis_tvalid, "result register empty after a pop")

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
module tb_top;
  import dtv_pkg::*;

  typedef struct packed {
    status_e     status;
    logic [15:0] ident;
    logic [15:0] version;
    logic [7:0]  checksum;
    logic [15:0] serial;
    logic [15:0] crc;
    logic [15:0] crc_len;
    logic [31:0] location;
  } tag_result_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i;
  logic [31:0]  cfg_data_i;

  descriptor_tag_verifier_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  int tx_idle_pct;
  int rx_idle_pct;
  int hold_cycles;
  int errors;

  logic [8:0]  cfg_expected_id;
  logic [15:0] cfg_max_version;
  logic        cfg_check_location;
  logic [31:0] cfg_expected_location;

  int          hdr_count;
  logic [7:0]  hdr_buf [16];
  logic [7:0]  hdr_sum;
  logic [15:0] body_seen;
  logic [15:0] body_crc;

  tag_result_t expected_tags [$];
  logic [7:0]  frame_bytes [$];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [15:0] ccitt_update(logic [15:0] crc, logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[15] ^ b[i];
      crc = {crc[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return crc;
  endfunction

  task automatic clear_tag_state();
    hdr_count = 0;
    hdr_sum   = 8'h00;
    body_seen = 16'h0000;
    body_crc  = 16'h0000;
    for (int i = 0; i < 16; i++) hdr_buf[i] = 8'h00;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last);
    tag_result_t r;
    if (hdr_count < 16) begin
      hdr_buf[hdr_count] = b;
      if (hdr_count != 4) hdr_sum = hdr_sum + b;
      hdr_count++;
    end else begin
      if (body_seen < {hdr_buf[11], hdr_buf[10]}) body_crc = ccitt_update(body_crc, b);
      if (body_seen != 16'hffff) body_seen++;
    end
    if (last) begin
      r.ident    = {hdr_buf[1], hdr_buf[0]};
      r.version  = {hdr_buf[3], hdr_buf[2]};
      r.checksum = hdr_buf[4];
      r.serial   = {hdr_buf[7], hdr_buf[6]};
      r.crc      = {hdr_buf[9], hdr_buf[8]};
      r.crc_len  = {hdr_buf[11], hdr_buf[10]};
      r.location = {hdr_buf[15], hdr_buf[14], hdr_buf[13], hdr_buf[12]};
      if (hdr_count < 16) r.status = ST_TRUNCATED;
      else if (hdr_sum != r.checksum) r.status = ST_CHECKSUM;
      else if ((r.ident > IdLowMax && r.ident < IdHighMin) || r.ident > IdMax ||
               (cfg_expected_id != 0 && r.ident != {7'd0, cfg_expected_id}))
        r.status = ST_ID;
      else if (r.version > cfg_max_version) r.status = ST_VERSION;
      else if (r.crc_len > MaxCrcLen) r.status = ST_TOO_LONG;
      else if (body_seen < r.crc_len) r.status = ST_TRUNCATED;
      else if (body_crc != r.crc) r.status = ST_CRC;
      else if (cfg_check_location && r.location != cfg_expected_location)
        r.status = ST_LOCATION;
      else r.status = ST_OK;
      expected_tags.push_back(r);
      clear_tag_state();
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    tag_result_t w;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_tags.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, m_axis_tdata);
          errors++;
        end else begin
          w = expected_tags.pop_front();
          compare_field("status", 32'(w.status), 32'(m_axis_tdata[2:0]));
          compare_field("tag_ident", 32'(w.ident), 32'(m_axis_tdata[18:3]));
          compare_field("tag_version", 32'(w.version), 32'(m_axis_tdata[34:19]));
          compare_field("tag_checksum", 32'(w.checksum), 32'(m_axis_tdata[42:35]));
          compare_field("serial_number", 32'(w.serial), 32'(m_axis_tdata[58:43]));
          compare_field("stored_crc", 32'(w.crc), 32'(m_axis_tdata[74:59]));
          compare_field("crc_length", 32'(w.crc_len), 32'(m_axis_tdata[90:75]));
          compare_field("tag_location", w.location, m_axis_tdata[122:91]);
          compare_field("padding", 32'd0, 32'(m_axis_tdata[127:123]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_byte(s_axis_tdata, s_axis_tlast);
    end
  end

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_frame(input int count);
    for (int i = 0; i < count; i++) send_byte(frame_bytes[i], i == count - 1);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_tags.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_EXPECTED_ID:       cfg_expected_id = value[8:0];
      CFG_MAX_VERSION:       cfg_max_version = value[15:0];
      CFG_CHECK_LOCATION:    cfg_check_location = value[0];
      CFG_EXPECTED_LOCATION: cfg_expected_location = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic build_frame(input logic [15:0] id, input logic [15:0] ver,
                             input logic [15:0] serial, input logic [15:0] crc_len,
                             input logic [31:0] loc, input int body_len,
                             input logic [7:0] cks_xor, input logic [15:0] crc_xor);
    logic [7:0]  body [$];
    logic [15:0] crc;
    logic [7:0]  sum;
    crc = 16'h0000;
    sum = 8'h00;
    for (int i = 0; i < body_len; i++) begin
      body.push_back(8'($urandom));
      if (i < crc_len) crc = ccitt_update(crc, body[i]);
    end
    crc = crc ^ crc_xor;
    frame_bytes.delete();
    frame_bytes = '{id[7:0], id[15:8], ver[7:0], ver[15:8], 8'h00, 8'($urandom),
                    serial[7:0], serial[15:8], crc[7:0], crc[15:8],
                    crc_len[7:0], crc_len[15:8], loc[7:0], loc[15:8], loc[23:16], loc[31:24]};
    for (int i = 0; i < 16; i++) if (i != 4) sum = sum + frame_bytes[i];
    frame_bytes[4] = sum ^ cks_xor;
    foreach (body[i]) frame_bytes.push_back(body[i]);
  endtask

  task automatic send_descriptor(input logic [15:0] id, input logic [15:0] ver,
                                 input logic [15:0] crc_len, input logic [31:0] loc,
                                 input int body_len, input logic [7:0] cks_xor,
                                 input logic [15:0] crc_xor);
    build_frame(id, ver, 16'($urandom), crc_len, loc, body_len, cks_xor, crc_xor);
    send_frame(frame_bytes.size());
  endtask

  task automatic random_descriptor();
    int          kind;
    logic [15:0] id;
    logic [15:0] ver;
    logic [15:0] crc_len;
    logic [31:0] loc;
    int          body_len;
    logic [7:0]  cks_xor;
    logic [15:0] crc_xor;
    kind = $urandom_range(99);
    if (kind >= 85) begin
      frame_bytes.delete();
      repeat ($urandom_range(1, 24)) frame_bytes.push_back(8'($urandom));
      send_frame(frame_bytes.size());
    end else begin
      id = (cfg_expected_id != 0) ? {7'd0, cfg_expected_id} :
           16'($urandom_range(1) ? $urandom_range(0, 9) : $urandom_range(256, 266));
      ver      = 16'($urandom_range(0, cfg_max_version));
      crc_len  = 16'($urandom_range(0, 12));
      body_len = int'(crc_len) + int'($urandom_range(0, 3));
      loc      = cfg_check_location ? cfg_expected_location : $urandom;
      cks_xor  = 8'h00;
      crc_xor  = 16'h0000;
      if ($urandom_range(99) < 30) begin
        case ($urandom_range(6))
          0: cks_xor = 8'($urandom_range(1, 255));
          1: crc_xor = 16'($urandom_range(1, 65535));
          2: id = 16'($urandom);
          3: ver = 16'($urandom);
          4: if (crc_len > 0) body_len = int'($urandom_range(0, crc_len - 1));
          5: crc_len = 16'($urandom);
          default: loc = loc ^ $urandom_range(1, 32'hffff_ffff);
        endcase
      end
      build_frame(id, ver, 16'($urandom), crc_len, loc, body_len, cks_xor, crc_xor);
      if (kind >= 70) send_frame($urandom_range(1, frame_bytes.size()));
      else send_frame(frame_bytes.size());
    end
  endtask

  task automatic test_directed_tags();
    send_descriptor(16'd1, 16'd2, 16'd0, 32'd0, 0, 8'h00, 16'h0000);
    send_descriptor(16'd9, 16'd3, 16'd4, 32'hffff_ffff, 4, 8'h00, 16'h0000);
    send_descriptor(16'd256, 16'd0, 16'd8, 32'h1234_5678, 10, 8'h00, 16'h0000);
    send_descriptor(16'd266, 16'd1, 16'd1, 32'd5, 1, 8'h00, 16'h0000);
    send_descriptor(16'd0, 16'd0, 16'd3, 32'd0, 3, 8'h00, 16'h0000);
    send_descriptor(16'd10, 16'd0, 16'd2, 32'd0, 2, 8'h00, 16'h0000);
    send_descriptor(16'd255, 16'd0, 16'd0, 32'd0, 0, 8'h00, 16'h0000);
    send_descriptor(16'd267, 16'd0, 16'd0, 32'd0, 0, 8'h00, 16'h0000);
    send_descriptor(16'hffff, 16'hffff, 16'hffff, 32'hffff_ffff, 0, 8'h00, 16'h0000);
    send_descriptor(16'd2, 16'd1, 16'd2, 32'd0, 2, 8'h01, 16'h0000);
    send_descriptor(16'd2, 16'd4, 16'd2, 32'd0, 2, 8'h00, 16'h0000);
    send_descriptor(16'd2, 16'hffff, 16'd0, 32'd0, 0, 8'h00, 16'h0000);
    send_descriptor(16'd3, 16'd3, 16'd8193, 32'd0, 1, 8'h00, 16'h0000);
    send_descriptor(16'd3, 16'd3, 16'hffff, 32'd0, 0, 8'h00, 16'h0000);
    send_descriptor(16'd3, 16'd3, MaxCrcLen, 32'd0, 0, 8'h00, 16'h0000);
    send_descriptor(16'd4, 16'd1, 16'd5, 32'd0, 3, 8'h00, 16'h0000);
    send_descriptor(16'd5, 16'd1, 16'd6, 32'd0, 6, 8'h00, 16'h8001);
    frame_bytes = '{8'hff};
    send_frame(1);
    build_frame(16'd1, 16'd1, 16'hffff, 16'd0, 32'hffff_ffff, 0, 8'h00, 16'h0000);
    send_frame(15);
    frame_bytes = '{8'h00, 8'h00, 8'h00, 8'h00};
    send_frame(4);
  endtask

  task automatic test_register_settings();
    write_reg(CFG_CHECK_LOCATION, 32'd1);
    write_reg(CFG_EXPECTED_LOCATION, 32'hffff_ffff);
    send_descriptor(16'd1, 16'd0, 16'd2, 32'hffff_ffff, 2, 8'h00, 16'h0000);
    send_descriptor(16'd1, 16'd0, 16'd2, 32'd0, 2, 8'h00, 16'h0000);
    write_reg(CFG_EXPECTED_LOCATION, 32'd0);
    send_descriptor(16'd1, 16'd0, 16'd0, 32'd0, 0, 8'h00, 16'h0000);
    send_descriptor(16'd1, 16'd0, 16'd0, 32'd1, 0, 8'h00, 16'h0000);
    write_reg(CFG_CHECK_LOCATION, 32'd0);
    write_reg(CFG_EXPECTED_ID, 32'd266);
    send_descriptor(16'd266, 16'd0, 16'd1, 32'd7, 1, 8'h00, 16'h0000);
    send_descriptor(16'd9, 16'd0, 16'd1, 32'd7, 1, 8'h00, 16'h0000);
    send_descriptor(16'd0, 16'd0, 16'd1, 32'd7, 1, 8'h00, 16'h0000);
    write_reg(CFG_EXPECTED_ID, 32'd1);
    write_reg(CFG_MAX_VERSION, 32'd0);
    send_descriptor(16'd1, 16'd0, 16'd1, 32'd7, 1, 8'h00, 16'h0000);
    send_descriptor(16'd1, 16'd1, 16'd1, 32'd7, 1, 8'h00, 16'h0000);
    write_reg(CFG_MAX_VERSION, 32'hffff);
    send_descriptor(16'd1, 16'hffff, 16'd1, 32'd7, 1, 8'h00, 16'h0000);
    write_reg(CFG_EXPECTED_ID, 32'd0);
    write_reg(CFG_MAX_VERSION, 32'd3);
  endtask

  task automatic test_random_stream(input int tx_pct, input int rx_pct, input int byte_budget);
    int start_count;
    int frames;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    frames      = 0;
    start_count = 0;
    while (start_count < byte_budget) begin
      if (frames % 8 == 0) begin
        write_reg(CFG_EXPECTED_ID, $urandom_range(1) ? 32'd0 :
                  ($urandom_range(1) ? $urandom_range(0, 9) : $urandom_range(256, 266)));
        write_reg(CFG_MAX_VERSION, $urandom_range(3) == 0 ? 32'hffff : $urandom_range(0, 65535));
        write_reg(CFG_CHECK_LOCATION, $urandom_range(1));
        write_reg(CFG_EXPECTED_LOCATION, $urandom);
      end
      random_descriptor();
      start_count += frame_bytes.size();
      frames++;
    end
  endtask

  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    wait_idle();
    hold_cycles = 250;
    for (int i = 0; i < 16; i++) begin
      if (i % 4 == 3) begin
        send_descriptor(16'd2, 16'd1, 16'd2, 32'd0, 2, 8'h00, 16'h0000);
      end else begin
        frame_bytes = '{8'($urandom), 8'($urandom), 8'($urandom)};
        send_frame($urandom_range(1, 3));
      end
    end
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_EXPECTED_ID;
    cfg_data_i    = 32'd0;
    tx_idle_pct   = 14;
    rx_idle_pct   = 48;
    hold_cycles   = 0;
    errors        = 0;
    cfg_expected_id       = 9'd0;
    cfg_max_version       = 16'd3;
    cfg_check_location    = 1'b0;
    cfg_expected_location = 32'd0;
    clear_tag_state();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_tags();
    test_register_settings();
    test_random_stream(14, 48, 130);
    test_random_stream(48, 14, 130);
    test_random_stream(0, 0, 130);
    test_output_backpressure();

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (expected_tags.size() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0", $time, expected_tags.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/dtv_pkg.sv
src/dtv_front.sv
src/dtv_queue.sv
src/dtv_back.sv
src/descriptor_tag_verifier_unit.sv
sim/tb_top.sv
